/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent in the cycle after the antecedent.
`define UFP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

// Consequent in the same cycle as the antecedent.
`define UFP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

`endif

/* rtl/ufp_pkg.sv */
// Constants, opcodes and result type of the flash programmer.
// No dependencies.
package ufp_pkg;

  localparam int STORE_BYTES  = 4096;
  localparam int PAGE_BYTES   = 256;
  localparam int SECTOR_BYTES = 65536;
  localparam int CHUNK_AW     = $clog2(STORE_BYTES);
  localparam int OFF_W        = CHUNK_AW + 1;
  localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
  localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);

  localparam logic [7:0] OP_WREN  = 8'h06;
  localparam logic [7:0] OP_RDSR  = 8'h05;
  localparam logic [7:0] OP_PROG  = 8'h02;
  localparam logic [7:0] OP_ERASE = 8'hD8;
  localparam logic [7:0] WIP_BIT  = 8'h01;
  localparam logic [7:0] BYTE_ACK = 8'h79;
  localparam logic [7:0] BYTE_NAK = 8'h6E;
  localparam logic [7:0] PAD_BYTE = 8'hFF;

  localparam logic [23:0] FLASH_BASE_RST = 24'h100000;
  localparam logic [24:0] MAX_IMAGE_RST  = 25'h0F00000;

  localparam logic DEST_SPI  = 1'b0;
  localparam logic DEST_HOST = 1'b1;

  localparam logic REQ_HOST  = 1'b0;
  localparam logic REQ_REPLY = 1'b1;

  localparam logic REG_FLASH_BASE = 1'b0;
  localparam logic REG_MAX_IMAGE  = 1'b1;

  typedef struct packed {
    logic       valid;
    logic       dest;
    logic [7:0] tx_byte;
    logic       select_before;
    logic       release_after;
    logic       session_done;
  } res_t;

endpackage

/* rtl/ufp_stream_if.sv */
// Valid/ready channel interfaces for request and result items.
// Depends on nothing.
interface ufp_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;
  modport source (output valid, req_type, data_byte, input ready);
  modport sink (input valid, req_type, data_byte, output ready);
endinterface

interface ufp_res_if;
  logic       valid;
  logic       ready;
  logic       dest;
  logic [7:0] tx_byte;
  logic       select_before;
  logic       release_after;
  logic       session_done;
  modport source (output valid, dest, tx_byte, select_before, release_after, session_done,
                  input ready);
  modport sink (input valid, dest, tx_byte, select_before, release_after, session_done,
                output ready);
endinterface

/* rtl/ufp_chunk_ram.sv */
// Single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ufp_chunk_ram #(
  parameter int AW = 12,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

/* rtl/ufp_ctrl.sv */
// Session sequencer: header, sector erase, chunk receive and page program.
// Depends on ufp_pkg; drives the chunk RAM ports.
module ufp_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         acc,
  input  logic                         req_type,
  input  logic [7:0]                   data_byte,
  input  logic [23:0]                  flash_base,
  input  logic [24:0]                  max_image_bytes,
  output logic                         wr_en,
  output logic [ufp_pkg::CHUNK_AW-1:0] wr_addr,
  output logic [7:0]                   wr_data,
  output logic [ufp_pkg::CHUNK_AW-1:0] rd_addr,
  input  logic [7:0]                   rd_data,
  output ufp_pkg::res_t                res
);
  typedef enum logic [2:0] {PH_HEADER, PH_ERASE, PH_RECV, PH_PROG, PH_OVER} phase_t;
  localparam int OW = ufp_pkg::OFF_W;

  phase_t           phase, phase_next;
  logic [1:0]       hcnt, hcnt_next;
  logic [31:0]      isize, isize_next;
  logic [24:0]      bleft, bleft_next;
  logic [23:0]      waddr, waddr_next;
  logic [9:0]       sleft, sleft_next;
  logic [2:0]       step, step_next;
  logic [OW-1:0]    fill, fill_next;
  logic [OW-1:0]    clen, clen_next;
  logic [OW-1:0]    soff, soff_next;

  logic             prog;
  logic [23:0]      addr;
  logic [OW-1:0]    soff_inc;
  logic [OW:0]      padded;
  logic             page_end_cur;
  logic             page_end_inc;
  logic [7:0]       byte_cur;
  logic [7:0]       byte_inc;
  logic [OW-1:0]    fill_inc;
  logic [24:0]      bleft_sub;
  logic [9:0]       sectors;

  function automatic ufp_pkg::res_t mk(logic d, logic [7:0] b, logic s, logic r, logic f);
    ufp_pkg::res_t t;
    t.valid = 1'b1;
    t.dest = d;
    t.tx_byte = b;
    t.select_before = s;
    t.release_after = r;
    t.session_done = f;
    return t;
  endfunction

  function automatic logic [OW-1:0] chunk_len(logic [24:0] left);
    if (left < 25'(ufp_pkg::STORE_BYTES)) begin
      return left[OW-1:0];
    end
    return OW'(ufp_pkg::STORE_BYTES);
  endfunction

  assign prog = (phase == PH_PROG);
  assign addr = prog ? waddr + 24'(soff) : waddr;
  assign soff_inc = soff + OW'(1);
  assign padded = (((OW+1)'(clen) + (OW+1)'(ufp_pkg::PAGE_BYTES - 1)) >> ufp_pkg::PAGE_SHIFT)
                  << ufp_pkg::PAGE_SHIFT;
  assign page_end_cur = (soff[ufp_pkg::PAGE_SHIFT-1:0] == '1);
  assign page_end_inc = (soff_inc[ufp_pkg::PAGE_SHIFT-1:0] == '1);
  assign byte_cur = (soff < clen) ? rd_data : ufp_pkg::PAD_BYTE;
  assign byte_inc = (soff_inc < clen) ? rd_data : ufp_pkg::PAD_BYTE;
  assign rd_addr = (step == 3'd5) ? soff_inc[ufp_pkg::CHUNK_AW-1:0]
                                  : soff[ufp_pkg::CHUNK_AW-1:0];
  assign fill_inc = fill + OW'(1);
  assign bleft_sub = bleft - 25'(clen);

  always_comb begin
    phase_next = phase;
    hcnt_next = hcnt;
    isize_next = isize;
    bleft_next = bleft;
    waddr_next = waddr;
    sleft_next = sleft;
    step_next = step;
    fill_next = fill;
    clen_next = clen;
    soff_next = soff;
    res = '0;
    wr_en = 1'b0;
    wr_addr = fill[ufp_pkg::CHUNK_AW-1:0];
    wr_data = data_byte;
    sectors = '0;
    if (acc) begin
      case (phase)
        PH_HEADER: begin
          if (req_type == ufp_pkg::REQ_HOST) begin
            isize_next = isize | (32'(data_byte) << {hcnt, 3'b000});
            hcnt_next = hcnt + 2'd1;
            sectors = 10'(isize_next[24:ufp_pkg::SECTOR_SHIFT])
                      + 10'(|isize_next[ufp_pkg::SECTOR_SHIFT-1:0]);
            if (hcnt == 2'd3) begin
              if (isize_next == 32'd0 || isize_next > 32'(max_image_bytes)) begin
                phase_next = PH_OVER;
                res = mk(ufp_pkg::DEST_HOST, ufp_pkg::BYTE_NAK, 1'b0, 1'b0, 1'b1);
              end else begin
                bleft_next = isize_next[24:0];
                sleft_next = sectors;
                waddr_next = flash_base;
                phase_next = PH_ERASE;
                step_next = 3'd0;
                res = mk(ufp_pkg::DEST_SPI, ufp_pkg::OP_WREN, 1'b1, 1'b1, 1'b0);
              end
            end
          end
        end
        PH_RECV: begin
          if (req_type == ufp_pkg::REQ_HOST) begin
            wr_en = 1'b1;
            fill_next = fill_inc;
            if (fill_inc >= clen) begin
              soff_next = '0;
              phase_next = PH_PROG;
              step_next = 3'd0;
              res = mk(ufp_pkg::DEST_SPI, ufp_pkg::OP_WREN, 1'b1, 1'b1, 1'b0);
            end
          end
        end
        PH_ERASE, PH_PROG: begin
          if (req_type == ufp_pkg::REQ_REPLY) begin
            case (step)
              3'd0: begin
                step_next = 3'd1;
                res = mk(ufp_pkg::DEST_SPI, prog ? ufp_pkg::OP_PROG : ufp_pkg::OP_ERASE,
                         1'b1, 1'b0, 1'b0);
              end
              3'd1: begin
                step_next = 3'd2;
                res = mk(ufp_pkg::DEST_SPI, addr[23:16], 1'b0, 1'b0, 1'b0);
              end
              3'd2: begin
                step_next = 3'd3;
                res = mk(ufp_pkg::DEST_SPI, addr[15:8], 1'b0, 1'b0, 1'b0);
              end
              3'd3: begin
                step_next = 3'd4;
                res = mk(ufp_pkg::DEST_SPI, addr[7:0], 1'b0, !prog, 1'b0);
              end
              3'd4: begin
                if (prog) begin
                  step_next = 3'd5;
                  res = mk(ufp_pkg::DEST_SPI, byte_cur, 1'b0, page_end_cur, 1'b0);
                end else begin
                  step_next = 3'd6;
                  res = mk(ufp_pkg::DEST_SPI, ufp_pkg::OP_RDSR, 1'b1, 1'b0, 1'b0);
                end
              end
              3'd5: begin
                if (page_end_cur) begin
                  step_next = 3'd6;
                  res = mk(ufp_pkg::DEST_SPI, ufp_pkg::OP_RDSR, 1'b1, 1'b0, 1'b0);
                end else begin
                  soff_next = soff_inc;
                  res = mk(ufp_pkg::DEST_SPI, byte_inc, 1'b0, page_end_inc, 1'b0);
                end
              end
              3'd6: begin
                step_next = 3'd7;
                res = mk(ufp_pkg::DEST_SPI, ufp_pkg::PAD_BYTE, 1'b0, 1'b1, 1'b0);
              end
              default: begin
                if ((data_byte & ufp_pkg::WIP_BIT) != 8'd0) begin
                  step_next = 3'd6;
                  res = mk(ufp_pkg::DEST_SPI, ufp_pkg::OP_RDSR, 1'b1, 1'b0, 1'b0);
                end else begin
                  step_next = 3'd0;
                  if (!prog) begin
                    waddr_next = waddr + 24'(ufp_pkg::SECTOR_BYTES);
                    sleft_next = (sleft != 10'd0) ? sleft - 10'd1 : sleft;
                    if (sleft_next == 10'd0) begin
                      waddr_next = flash_base;
                      phase_next = PH_RECV;
                      fill_next = '0;
                      clen_next = chunk_len(bleft);
                      res = mk(ufp_pkg::DEST_HOST, ufp_pkg::BYTE_ACK, 1'b0, 1'b0, 1'b0);
                    end else begin
                      res = mk(ufp_pkg::DEST_SPI, ufp_pkg::OP_WREN, 1'b1, 1'b1, 1'b0);
                    end
                  end else if ((OW+1)'(soff_inc) >= padded) begin
                    waddr_next = waddr + 24'(padded);
                    bleft_next = bleft_sub;
                    if (bleft_sub == 25'd0) begin
                      phase_next = PH_OVER;
                      res = mk(ufp_pkg::DEST_HOST, ufp_pkg::BYTE_ACK, 1'b0, 1'b0, 1'b1);
                    end else begin
                      phase_next = PH_RECV;
                      fill_next = '0;
                      clen_next = chunk_len(bleft_sub);
                      res = mk(ufp_pkg::DEST_HOST, ufp_pkg::BYTE_ACK, 1'b0, 1'b0, 1'b0);
                    end
                  end else begin
                    soff_next = soff_inc;
                    res = mk(ufp_pkg::DEST_SPI, ufp_pkg::OP_WREN, 1'b1, 1'b1, 1'b0);
                  end
                end
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      hcnt <= '0;
      isize <= '0;
      bleft <= '0;
      waddr <= '0;
      sleft <= '0;
      step <= '0;
      fill <= '0;
      clen <= '0;
      soff <= '0;
    end else begin
      phase <= phase_next;
      hcnt <= hcnt_next;
      isize <= isize_next;
      bleft <= bleft_next;
      waddr <= waddr_next;
      sleft <= sleft_next;
      step <= step_next;
      fill <= fill_next;
      clen <= clen_next;
      soff <= soff_next;
    end
  end
endmodule

/* rtl/uart_to_spi_flash_programmer_core.sv */
// Top level of the SPI NOR flash programmer: APB registers, sequencer, chunk RAM, result queue.
// Depends on ufp_pkg, ufp_stream_if, ufp_chunk_ram and ufp_ctrl.
//
// req_ch carries host bytes (req_type 0) and flash reply bytes (req_type 1).
// res_ch carries SPI transfers (dest 0) and host reply bytes (dest 1).
// Each issued SPI transfer must be answered with one reply item before the next.
// An item's result, if any, is registered into the result queue and reaches res_ch
// behind any older queued results. In the cycle after each accept the input rests while the
// chunk RAM read for the next data byte completes, so the input cannot take a new item
// directly after the last one.
// A two-entry result queue lets input transfers continue while res_ch stalls;
// beside the rest cycle, req_ch ready drops while the queue is full.
// Reset returns to waiting for the size header and restores flash_base
// (0x100000) and max_image_bytes (0xF00000). Chunk RAM contents are kept.
// After NAK or the final ACK, which carry session_done, input is dropped until reset.
// Registers: flash_base at 0x0, max_image_bytes at 0x4; write only while idle.
module uart_to_spi_flash_programmer_core (
  input  logic        clk,
  input  logic        rst,
  ufp_req_if.sink     req_ch,
  ufp_res_if.source   res_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [23:0]   flash_base;
  logic [24:0]   max_image_bytes;
  logic          gap;
  logic          acc;
  logic          push;
  logic          pop;
  logic [1:0]    cnt;
  ufp_pkg::res_t res;
  ufp_pkg::res_t q0, q1;
  logic          wr_en;
  logic [ufp_pkg::CHUNK_AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ufp_pkg::REG_MAX_IMAGE) ? {7'd0, max_image_bytes}
                                                       : {8'd0, flash_base};

  always_ff @(posedge clk) begin
    if (rst) begin
      flash_base <= ufp_pkg::FLASH_BASE_RST;
      max_image_bytes <= ufp_pkg::MAX_IMAGE_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == ufp_pkg::REG_MAX_IMAGE) begin
        max_image_bytes <= pwdata[24:0];
      end else begin
        flash_base <= pwdata[23:0];
      end
    end
  end

  assign req_ch.ready = !gap && (cnt != 2'd2);
  assign acc = req_ch.valid && req_ch.ready;
  assign push = acc && res.valid;
  assign pop = res_ch.valid && res_ch.ready;

  ufp_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .acc(acc),
    .req_type(req_ch.req_type),
    .data_byte(req_ch.data_byte),
    .flash_base(flash_base),
    .max_image_bytes(max_image_bytes),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .res(res)
  );

  ufp_chunk_ram #(.AW(ufp_pkg::CHUNK_AW), .DW(8)) u_ram (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= 1'b0;
      cnt <= '0;
    end else begin
      gap <= acc;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
    if (push && ((cnt - 2'(pop)) == 2'd0)) begin
      q0 <= res;
    end else if (pop) begin
      q0 <= q1;
    end
    if (push && ((cnt - 2'(pop)) != 2'd0)) begin
      q1 <= res;
    end
  end

  assign res_ch.valid = (cnt != 2'd0);
  assign res_ch.dest = q0.dest;
  assign res_ch.tx_byte = q0.tx_byte;
  assign res_ch.select_before = q0.select_before;
  assign res_ch.release_after = q0.release_after;
  assign res_ch.session_done = q0.session_done;
endmodule

/* rtl/ufp_checker.sv */
// Port-level checks of the flash programmer top level, bound to it.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ufp_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] res_tx_byte,
  input logic       res_session_done
);
  logic req_xfer;
  logic res_xfer;

  assign req_xfer = req_valid && req_ready;
  assign res_xfer = res_valid && res_ready;

  `UFP_ASSERT_NEXT(a_req_spacing, clk, rst, req_xfer, !req_xfer)
  `UFP_ASSERT_NEXT(a_done_last, clk, rst, res_xfer && res_session_done, !res_valid)
  `UFP_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid)
  `UFP_ASSERT_NEXT(a_res_stable, clk, rst, res_valid && !res_ready, $stable(res_tx_byte))
endmodule

bind uart_to_spi_flash_programmer_core ufp_checker u_ufp_checker (
  .clk(clk),
  .rst(rst),
  .req_valid(req_ch.valid),
  .req_ready(req_ch.ready),
  .res_valid(res_ch.valid),
  .res_ready(res_ch.ready),
  .res_tx_byte(res_ch.tx_byte),
  .res_session_done(res_ch.session_done)
);

/* tb/uart_to_spi_flash_programmer_core_tb.sv */
// Testbench for uart_to_spi_flash_programmer_core: drives one programming session
// (header, erase, chunk programming) and checks every result against a predictor.
// Depends on ufp_pkg, ufp_stream_if and the core.
`timescale 1ns / 1ps

module uart_to_spi_flash_programmer_core_tb;

  typedef enum logic [2:0] {PH_HEADER, PH_ERASE, PH_RECV, PH_PROG, PH_OVER} phase_t;

  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ufp_req_if req_ch ();
  ufp_res_if res_ch ();

  uart_to_spi_flash_programmer_core uut (
    .clk(clk), .rst(rst), .req_ch(req_ch.sink), .res_ch(res_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [23:0] base_addr;
  logic [24:0] size_limit;
  phase_t      phase;
  int unsigned hdr_count;
  logic [31:0] image_size;
  logic [31:0] bytes_left;
  logic [23:0] write_addr;
  int unsigned sectors_left;
  int unsigned cmd_step;
  logic [7:0]  data_store [ufp_pkg::STORE_BYTES];
  int unsigned fill_count;
  int unsigned chunk_len;
  int unsigned send_off;

  ufp_pkg::res_t expected_transfers [$];
  int          fail_count;
  int          idle_cycles;
  int          quiet_req;
  int          quiet_res;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int draw_gap(ref int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) quiet = $urandom_range(10, 40);
    return $urandom_range(0, 19);
  endfunction

  function automatic ufp_pkg::res_t transfer(logic d, logic [7:0] b, logic s, logic r,
                                             logic done);
    ufp_pkg::res_t t;
    t.valid = 1'b1;
    t.dest = d;
    t.tx_byte = b;
    t.select_before = s;
    t.release_after = r;
    t.session_done = done;
    return t;
  endfunction

  function automatic logic [7:0] byte_at(int unsigned off);
    return (off < chunk_len) ? data_store[off % ufp_pkg::STORE_BYTES] : ufp_pkg::PAD_BYTE;
  endfunction

  function automatic void open_chunk();
    phase = PH_RECV;
    fill_count = 0;
    chunk_len = (bytes_left < ufp_pkg::STORE_BYTES) ? bytes_left : ufp_pkg::STORE_BYTES;
  endfunction

  function automatic ufp_pkg::res_t flash_step(logic [7:0] reply);
    ufp_pkg::res_t t;
    logic        prog;
    logic [23:0] a;
    int unsigned padded;
    t = '0;
    prog = (phase == PH_PROG);
    a = prog ? write_addr + 24'(send_off) : write_addr;
    padded = ((chunk_len + ufp_pkg::PAGE_BYTES - 1) / ufp_pkg::PAGE_BYTES)
             * ufp_pkg::PAGE_BYTES;
    case (cmd_step)
      0: begin
        cmd_step = 1;
        t = transfer(ufp_pkg::DEST_SPI, prog ? ufp_pkg::OP_PROG : ufp_pkg::OP_ERASE,
                     1'b1, 1'b0, 1'b0);
      end
      1: begin
        cmd_step = 2;
        t = transfer(ufp_pkg::DEST_SPI, a[23:16], 1'b0, 1'b0, 1'b0);
      end
      2: begin
        cmd_step = 3;
        t = transfer(ufp_pkg::DEST_SPI, a[15:8], 1'b0, 1'b0, 1'b0);
      end
      3: begin
        cmd_step = 4;
        t = transfer(ufp_pkg::DEST_SPI, a[7:0], 1'b0, !prog, 1'b0);
      end
      4: begin
        if (prog) begin
          cmd_step = 5;
          t = transfer(ufp_pkg::DEST_SPI, byte_at(send_off), 1'b0,
                       ((send_off + 1) % ufp_pkg::PAGE_BYTES) == 0, 1'b0);
        end else begin
          cmd_step = 6;
          t = transfer(ufp_pkg::DEST_SPI, ufp_pkg::OP_RDSR, 1'b1, 1'b0, 1'b0);
        end
      end
      5: begin
        if (((send_off + 1) % ufp_pkg::PAGE_BYTES) == 0) begin
          cmd_step = 6;
          t = transfer(ufp_pkg::DEST_SPI, ufp_pkg::OP_RDSR, 1'b1, 1'b0, 1'b0);
        end else begin
          send_off++;
          t = transfer(ufp_pkg::DEST_SPI, byte_at(send_off), 1'b0,
                       ((send_off + 1) % ufp_pkg::PAGE_BYTES) == 0, 1'b0);
        end
      end
      6: begin
        cmd_step = 7;
        t = transfer(ufp_pkg::DEST_SPI, ufp_pkg::PAD_BYTE, 1'b0, 1'b1, 1'b0);
      end
      7: begin
        if ((reply & ufp_pkg::WIP_BIT) != 0) begin
          cmd_step = 6;
          t = transfer(ufp_pkg::DEST_SPI, ufp_pkg::OP_RDSR, 1'b1, 1'b0, 1'b0);
        end else begin
          cmd_step = 0;
          if (!prog) begin
            if (sectors_left > 0) sectors_left--;
            write_addr = write_addr + 24'(ufp_pkg::SECTOR_BYTES);
            if (sectors_left == 0) begin
              write_addr = base_addr;
              open_chunk();
              t = transfer(ufp_pkg::DEST_HOST, ufp_pkg::BYTE_ACK, 1'b0, 1'b0, 1'b0);
            end else begin
              t = transfer(ufp_pkg::DEST_SPI, ufp_pkg::OP_WREN, 1'b1, 1'b1, 1'b0);
            end
          end else if (send_off + 1 >= padded) begin
            write_addr = write_addr + 24'(padded);
            bytes_left = bytes_left - chunk_len;
            if (bytes_left == 0) begin
              phase = PH_OVER;
              t = transfer(ufp_pkg::DEST_HOST, ufp_pkg::BYTE_ACK, 1'b0, 1'b0, 1'b1);
            end else begin
              open_chunk();
              t = transfer(ufp_pkg::DEST_HOST, ufp_pkg::BYTE_ACK, 1'b0, 1'b0, 1'b0);
            end
          end else begin
            send_off++;
            t = transfer(ufp_pkg::DEST_SPI, ufp_pkg::OP_WREN, 1'b1, 1'b1, 1'b0);
          end
        end
      end
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic ufp_pkg::res_t predict_transfer(logic rq, logic [7:0] b);
    ufp_pkg::res_t t;
    t = '0;
    case (phase)
      PH_HEADER: begin
        if (rq == ufp_pkg::REQ_HOST) begin
          image_size = image_size | (32'(b) << (8 * hdr_count));
          hdr_count++;
          if (hdr_count == 4) begin
            hdr_count = 0;
            if (image_size == 0 || image_size > 32'(size_limit)) begin
              phase = PH_OVER;
              t = transfer(ufp_pkg::DEST_HOST, ufp_pkg::BYTE_NAK, 1'b0, 1'b0, 1'b1);
            end else begin
              bytes_left = image_size;
              sectors_left = image_size / ufp_pkg::SECTOR_BYTES
                             + ((image_size % ufp_pkg::SECTOR_BYTES) != 0);
              write_addr = base_addr;
              phase = PH_ERASE;
              cmd_step = 0;
              t = transfer(ufp_pkg::DEST_SPI, ufp_pkg::OP_WREN, 1'b1, 1'b1, 1'b0);
            end
          end
        end
      end
      PH_ERASE, PH_PROG: if (rq == ufp_pkg::REQ_REPLY) t = flash_step(b);
      PH_RECV: begin
        if (rq == ufp_pkg::REQ_HOST) begin
          data_store[fill_count % ufp_pkg::STORE_BYTES] = b;
          fill_count++;
          if (fill_count >= chunk_len) begin
            send_off = 0;
            phase = PH_PROG;
            cmd_step = 0;
            t = transfer(ufp_pkg::DEST_SPI, ufp_pkg::OP_WREN, 1'b1, 1'b1, 1'b0);
          end
        end
      end
      default: t = '0;
    endcase
    return t;
  endfunction

  task automatic send_item(logic rq, logic [7:0] b);
    int   gap;
    ufp_pkg::res_t t;
    gap = draw_gap(quiet_req);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= rq;
    req_ch.data_byte <= b;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    t = predict_transfer(rq, b);
    if (t.valid) expected_transfers.push_back(t);
  endtask

  task automatic drain_transfers();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_transfers.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == ufp_pkg::REG_FLASH_BASE) base_addr = value[23:0];
    else size_limit = value[24:0];
  endtask

  // answer the flash; status replies carry a busy bit now and then
  task automatic send_reply();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (cmd_step == 7) b[0] = ($urandom_range(0, 3) == 0);
    drain_transfers();
    send_item(ufp_pkg::REQ_REPLY, b);
  endtask

  task automatic test_header(int unsigned size);
    drain_transfers();
    write_reg(ufp_pkg::REG_FLASH_BASE, 32'hFFFFFF);
    write_reg(ufp_pkg::REG_MAX_IMAGE, 32'd1);
    send_item(ufp_pkg::REQ_REPLY, 8'hFF);
    send_item(ufp_pkg::REQ_HOST, size[7:0]);
    send_item(ufp_pkg::REQ_REPLY, 8'h00);
    send_item(ufp_pkg::REQ_HOST, size[15:8]);
    drain_transfers();
    write_reg(ufp_pkg::REG_MAX_IMAGE, 32'h1000000);
    write_reg(ufp_pkg::REG_FLASH_BASE, 32'h0);
    send_item(ufp_pkg::REQ_HOST, size[23:16]);
    drain_transfers();
    write_reg(ufp_pkg::REG_MAX_IMAGE, size);
    write_reg(ufp_pkg::REG_FLASH_BASE, 32'hFFFF80);
    send_item(ufp_pkg::REQ_HOST, size[31:24]);
  endtask

  task automatic test_erase();
    while (phase == PH_ERASE) begin
      if ($urandom_range(0, 24) == 0) begin
        send_item(ufp_pkg::REQ_HOST, 8'($urandom_range(0, 255)));
      end else begin
        send_reply();
      end
    end
    drain_transfers();
    write_reg(ufp_pkg::REG_FLASH_BASE, 32'h0);
  endtask

  task automatic test_program();
    while (phase != PH_OVER) begin
      if (phase == PH_RECV) begin
        if ($urandom_range(0, 29) == 0) begin
          send_item(ufp_pkg::REQ_REPLY, 8'($urandom_range(0, 255)));
        end else begin
          send_item(ufp_pkg::REQ_HOST, 8'($urandom_range(0, 255)));
        end
      end else if ($urandom_range(0, 29) == 0) begin
        send_item(ufp_pkg::REQ_HOST, 8'($urandom_range(0, 255)));
      end else begin
        send_reply();
      end
    end
  endtask

  task automatic test_session_over();
    repeat (8) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    drain_transfers();
  endtask

  always @(posedge clk) begin
    ufp_pkg::res_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_transfers.size() == 0) begin
        $error("unexpected transfer: dest %0d tx_byte %02h", res_ch.dest, res_ch.tx_byte);
        fail_count++;
      end else begin
        want = expected_transfers.pop_front();
        if (res_ch.dest !== want.dest) begin
          $error("dest: expected %0d, got %0d", want.dest, res_ch.dest);
          fail_count++;
        end
        if (res_ch.tx_byte !== want.tx_byte) begin
          $error("tx_byte: expected %02h, got %02h", want.tx_byte, res_ch.tx_byte);
          fail_count++;
        end
        if (res_ch.select_before !== want.select_before) begin
          $error("select_before: expected %0d, got %0d", want.select_before,
                 res_ch.select_before);
          fail_count++;
        end
        if (res_ch.release_after !== want.release_after) begin
          $error("release_after: expected %0d, got %0d", want.release_after,
                 res_ch.release_after);
          fail_count++;
        end
        if (res_ch.session_done !== want.session_done) begin
          $error("session_done: expected %0d, got %0d", want.session_done,
                 res_ch.session_done);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int n;
    res_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      n = draw_gap(quiet_res);
      if (n > 0) begin
        res_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned size;
    fail_count = 0;
    idle_cycles = 0;
    quiet_req = 0;
    quiet_res = 0;
    base_addr = ufp_pkg::FLASH_BASE_RST;
    size_limit = ufp_pkg::MAX_IMAGE_RST;
    phase = PH_HEADER;
    hdr_count = 0;
    image_size = 0;
    bytes_left = 0;
    write_addr = 0;
    sectors_left = 0;
    cmd_step = 0;
    fill_count = 0;
    chunk_len = 0;
    send_off = 0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = ufp_pkg::REQ_HOST;
    req_ch.data_byte = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    size = $urandom_range(150, 300);
    test_header(size);
    test_erase();
    test_program();
    test_session_over();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_transfers.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
